FILE: design/lpt_pkg.sv
// ----------------------------------------------------------------------------
// lpt_pkg: shared types and constants for the luma posterize threshold block
// Holds the pixel beat type, register indexes, effect mode codes and the
// fixed constants used by the quantizer.
// ----------------------------------------------------------------------------
`default_nettype none

package lpt_pkg;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] cb;
    logic [7:0] cr;
    logic [7:0] alpha;
  } pix_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_LEVELS       = 3'd0;
  localparam logic [2:0] REG_THRESHOLD_A  = 3'd1;
  localparam logic [2:0] REG_THRESHOLD_B  = 3'd2;
  localparam logic [2:0] REG_EFFECT_MODE  = 3'd3;
  localparam logic [2:0] REG_LUMA_FLOOR   = 3'd4;
  localparam logic [2:0] REG_LUMA_CEILING = 3'd5;

  // Effect modes.
  localparam logic [2:0] MODE_FLOOR_OUT   = 3'd0;
  localparam logic [2:0] MODE_POSTERIZE   = 3'd1;
  localparam logic [2:0] MODE_CLAMP       = 3'd2;
  localparam logic [2:0] MODE_ALPHA_KEY   = 3'd3;
  localparam logic [2:0] MODE_ALPHA_Q     = 3'd4;
  localparam logic [2:0] MODE_ALPHA_CLAMP = 3'd5;

  // Full luma range; the step is this value divided by the level count.
  localparam logic [8:0] LUMA_RANGE  = 9'd256;
  localparam logic [8:0] LEVELS_MIN  = 9'd1;
  localparam logic [8:0] LEVELS_MAX  = 9'd256;
  localparam logic [7:0] CHROMA_ZERO = 8'd128;

  // Reset values of the configuration registers.
  localparam logic [8:0] RST_LEVELS       = 9'd4;
  localparam logic [8:0] RST_THRESHOLD_A  = 9'd16;
  localparam logic [8:0] RST_THRESHOLD_B  = 9'd235;
  localparam logic [2:0] RST_EFFECT_MODE  = MODE_FLOOR_OUT;
  localparam logic [7:0] RST_LUMA_FLOOR   = 8'd16;
  localparam logic [7:0] RST_LUMA_CEILING = 8'd235;

endpackage

`default_nettype wire

FILE: design/luma_posterize_threshold_core.sv
// ----------------------------------------------------------------------------
// luma_posterize_threshold_core: posterize with a luma threshold window
// Quantizes luma to a multiple of 256/levels, compares it with a threshold
// window and rewrites luma, chroma or alpha according to the effect mode.
// ----------------------------------------------------------------------------
`default_nettype none

// The block takes one pixel beat per clock and returns one pixel beat per
// clock while the output is not held off by out_ready. A beat passes through
// six pipeline stages, the edge that accepts it loading the first one and the
// last being the output register: two stages work out the quantization step
// 256/levels as a restoring division (five and four quotient bits), two
// stages divide the luma sample by that step (four bits each) to get the
// remainder, one stage forms the quantized level and compares it with the
// window, and the last stage applies the effect mode into the output
// register. Every stage has its
// own valid bit and moves forward whenever the stage after it is empty or
// moving, so bubbles close up and a stalled output holds its beat while
// earlier stages keep filling. Configuration registers are written through a
// plain write port and must only change while no beat is in flight; each
// beat reads them as it passes through the stages. A level count of zero
// acts as one and a count above 256 acts as 256; thresholds given in reverse
// order are swapped; effect modes six and seven pass the pixel unchanged.
module luma_posterize_threshold_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Input pixel channel.
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_luma_in,
  input  wire logic [7:0] in_cb_in,
  input  wire logic [7:0] in_cr_in,
  input  wire logic [7:0] in_alpha_in,
  // Result pixel channel.
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_luma_out,
  output logic [7:0]      out_cb_out,
  output logic [7:0]      out_cr_out,
  output logic [7:0]      out_alpha_out,
  // Configuration write port.
  input  wire logic       cfg_wr_en,
  input  wire logic [2:0] cfg_index,
  input  wire logic [8:0] cfg_wdata
);

  import lpt_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [8:0] levels_r;
  logic [8:0] threshold_a_r;
  logic [8:0] threshold_b_r;
  logic [2:0] effect_mode_r;
  logic [7:0] luma_floor_r;
  logic [7:0] luma_ceiling_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r       <= RST_LEVELS;
      threshold_a_r  <= RST_THRESHOLD_A;
      threshold_b_r  <= RST_THRESHOLD_B;
      effect_mode_r  <= RST_EFFECT_MODE;
      luma_floor_r   <= RST_LUMA_FLOOR;
      luma_ceiling_r <= RST_LUMA_CEILING;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_LEVELS:       levels_r       <= cfg_wdata;
        REG_THRESHOLD_A:  threshold_a_r  <= cfg_wdata;
        REG_THRESHOLD_B:  threshold_b_r  <= cfg_wdata;
        REG_EFFECT_MODE:  effect_mode_r  <= cfg_wdata[2:0];
        REG_LUMA_FLOOR:   luma_floor_r   <= cfg_wdata[7:0];
        REG_LUMA_CEILING: luma_ceiling_r <= cfg_wdata[7:0];
        default: begin
          // Writes beyond the register list are ignored.
        end
      endcase
    end
  end

  // The level count clamped into 1..256, used as the step divisor.
  logic [8:0] levels_clamped;
  always_comb begin
    if (levels_r < LEVELS_MIN) begin
      levels_clamped = LEVELS_MIN;
    end else if (levels_r > LEVELS_MAX) begin
      levels_clamped = LEVELS_MAX;
    end else begin
      levels_clamped = levels_r;
    end
  end

  // Window ends in ascending order.
  logic [8:0] thr_lo;
  logic [8:0] thr_hi;
  always_comb begin
    if (threshold_b_r < threshold_a_r) begin
      thr_lo = threshold_b_r;
      thr_hi = threshold_a_r;
    end else begin
      thr_lo = threshold_a_r;
      thr_hi = threshold_b_r;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control. A stage loads when it is empty or when the stage
  // after it is moving its beat on.
  // --------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic en1, en2, en3, en4, en5, en6;

  assign en6 = !v6_r || out_ready;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
    end
  end

  pix_t in_pix;
  assign in_pix = '{luma: in_luma_in, cb: in_cb_in, cr: in_cr_in, alpha: in_alpha_in};

  // --------------------------------------------------------------------------
  // Stage 1: step = 256 / levels, quotient bits 8 down to 4.
  // --------------------------------------------------------------------------
  pix_t       pix1_r;
  logic [7:0] srem1_r, srem1_nxt;
  logic [4:0] squo1_r, squo1_nxt;

  always_comb begin
    logic [8:0] trial;
    logic [8:0] num;
    srem1_nxt = '0;
    squo1_nxt = '0;
    num       = LUMA_RANGE;
    for (int i = 0; i < 5; i++) begin
      trial = {srem1_nxt, num[8]};
      num   = {num[7:0], 1'b0};
      if (trial >= levels_clamped) begin
        trial     = trial - levels_clamped;
        squo1_nxt = {squo1_nxt[3:0], 1'b1};
      end else begin
        squo1_nxt = {squo1_nxt[3:0], 1'b0};
      end
      srem1_nxt = trial[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      pix1_r  <= in_pix;
      srem1_r <= srem1_nxt;
      squo1_r <= squo1_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: quotient bits 3 down to 0 complete the step.
  // --------------------------------------------------------------------------
  pix_t       pix2_r;
  logic [8:0] step2_r, step2_nxt;

  always_comb begin
    logic [8:0] trial;
    logic [7:0] rem;
    logic [3:0] num;
    rem       = srem1_r;
    num       = LUMA_RANGE[3:0];
    step2_nxt = {4'b0, squo1_r};
    for (int i = 0; i < 4; i++) begin
      trial = {rem, num[3]};
      num   = {num[2:0], 1'b0};
      if (trial >= levels_clamped) begin
        trial     = trial - levels_clamped;
        step2_nxt = {step2_nxt[7:0], 1'b1};
      end else begin
        step2_nxt = {step2_nxt[7:0], 1'b0};
      end
      rem = trial[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      pix2_r  <= pix1_r;
      step2_r <= step2_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: luma / step, upper four luma bits. Only the remainder matters.
  // --------------------------------------------------------------------------
  pix_t       pix3_r;
  logic [8:0] step3_r;
  logic [7:0] yrem3_r, yrem3_nxt;

  always_comb begin
    logic [8:0] trial;
    logic [3:0] num;
    yrem3_nxt = '0;
    num       = pix2_r.luma[7:4];
    for (int i = 0; i < 4; i++) begin
      trial = {yrem3_nxt, num[3]};
      num   = {num[2:0], 1'b0};
      if (trial >= step2_r) begin
        trial = trial - step2_r;
      end
      yrem3_nxt = trial[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      pix3_r  <= pix2_r;
      step3_r <= step2_r;
      yrem3_r <= yrem3_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: lower four luma bits give the final remainder.
  // --------------------------------------------------------------------------
  pix_t       pix4_r;
  logic [7:0] yrem4_r, yrem4_nxt;

  always_comb begin
    logic [8:0] trial;
    logic [3:0] num;
    yrem4_nxt = yrem3_r;
    num       = pix3_r.luma[3:0];
    for (int i = 0; i < 4; i++) begin
      trial = {yrem4_nxt, num[3]};
      num   = {num[2:0], 1'b0};
      if (trial >= step3_r) begin
        trial = trial - step3_r;
      end
      yrem4_nxt = trial[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      pix4_r  <= pix3_r;
      yrem4_r <= yrem4_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: quantized level and window compare.
  // --------------------------------------------------------------------------
  pix_t       pix5_r;
  logic [7:0] q5_r, q5_nxt;
  logic       below5_r, above5_r;

  assign q5_nxt = pix4_r.luma - yrem4_r;

  always_ff @(posedge clk) begin
    if (en5) begin
      pix5_r   <= pix4_r;
      q5_r     <= q5_nxt;
      below5_r <= {1'b0, q5_nxt} < thr_lo;
      above5_r <= {1'b0, q5_nxt} > thr_hi;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: effect mode applied into the output register.
  // --------------------------------------------------------------------------
  pix_t pix6_r, pix6_nxt;

  always_comb begin
    logic in_win;
    logic desat;
    in_win   = !below5_r && !above5_r;
    desat    = 1'b0;
    pix6_nxt = pix5_r;
    case (effect_mode_r)
      MODE_FLOOR_OUT: begin
        if (in_win) begin
          pix6_nxt.luma = q5_r;
        end else begin
          pix6_nxt.luma = luma_floor_r;
          desat         = 1'b1;
        end
      end
      MODE_POSTERIZE: begin
        pix6_nxt.luma = q5_r;
        desat         = in_win;
      end
      MODE_CLAMP: begin
        if (below5_r) begin
          pix6_nxt.luma = luma_floor_r;
          desat         = 1'b1;
        end else if (above5_r) begin
          pix6_nxt.luma = luma_ceiling_r;
          desat         = 1'b1;
        end else begin
          pix6_nxt.luma = q5_r;
        end
      end
      MODE_ALPHA_KEY: begin
        if (!in_win) pix6_nxt.alpha = luma_floor_r;
      end
      MODE_ALPHA_Q: begin
        if (in_win) pix6_nxt.alpha = q5_r;
      end
      MODE_ALPHA_CLAMP: begin
        if (below5_r) begin
          pix6_nxt.alpha = luma_floor_r;
        end else if (above5_r) begin
          pix6_nxt.alpha = luma_ceiling_r;
        end else begin
          pix6_nxt.alpha = q5_r;
        end
      end
      default: begin
        // Unused mode codes pass the pixel through.
      end
    endcase
    if (desat) begin
      pix6_nxt.cb = CHROMA_ZERO;
      pix6_nxt.cr = CHROMA_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      pix6_r <= pix6_nxt;
    end
  end

  assign out_valid     = v6_r;
  assign out_luma_out  = pix6_r.luma;
  assign out_cb_out    = pix6_r.cb;
  assign out_cr_out    = pix6_r.cr;
  assign out_alpha_out = pix6_r.alpha;

endmodule

`default_nettype wire

FILE: tb/tb_luma_posterize_threshold_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_luma_posterize_threshold_core: self-checking bench for the posterize core
// Streams pixel beats through the core under a series of register settings,
// predicts every result beat in the bench and compares all four fields in
// order, with random idle cycles on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_luma_posterize_threshold_core;
  import lpt_pkg::*;

  // Mode codes the package leaves unnamed; the core passes the pixel through.
  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;

  // The core is six stages deep, the last being the output register; the settle wait adds a margin.
  localparam int PIPE_LATENCY = 6;
  localparam int PIPE_SETTLE  = PIPE_LATENCY + 4;
  localparam int RANDOM_BEATS = 1600;
  localparam int HOLD_CYCLES  = 200;
  localparam int MAX_REPORTS  = 10;

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_ready;
  logic [7:0] in_luma_in    = 8'd0;
  logic [7:0] in_cb_in      = 8'd0;
  logic [7:0] in_cr_in      = 8'd0;
  logic [7:0] in_alpha_in   = 8'd0;
  logic       out_valid;
  logic       out_ready     = 1'b0;
  logic [7:0] out_luma_out;
  logic [7:0] out_cb_out;
  logic [7:0] out_cr_out;
  logic [7:0] out_alpha_out;
  logic       cfg_wr_en     = 1'b0;
  logic [2:0] cfg_index     = 3'd0;
  logic [8:0] cfg_wdata     = 9'd0;

  // Bench copy of the configuration registers, starting at their reset values.
  logic [8:0] lvl_reg   = RST_LEVELS;
  logic [8:0] thr_a_reg = RST_THRESHOLD_A;
  logic [8:0] thr_b_reg = RST_THRESHOLD_B;
  logic [2:0] mode_reg  = RST_EFFECT_MODE;
  logic [7:0] floor_reg = RST_LUMA_FLOOR;
  logic [7:0] ceil_reg  = RST_LUMA_CEILING;

  // Pixels waiting to be offered, and predicted pixels waiting to come out.
  pix_t pix_pending_q[$];
  pix_t pix_expect_q[$];

  int   tx_gap     = 0;
  int   rx_wait    = 0;
  logic tx_steady  = 1'b0;
  logic rx_steady  = 1'b0;
  logic rx_hold    = 1'b0;
  int   beats_in   = 0;
  int   beats_out  = 0;
  int   bad_beats  = 0;
  int   settings   = 0;
  logic [7:0] modes_seen = 8'd0;

  luma_posterize_threshold_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_luma_in    (in_luma_in),
    .in_cb_in      (in_cb_in),
    .in_cr_in      (in_cr_in),
    .in_alpha_in   (in_alpha_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_luma_out  (out_luma_out),
    .out_cb_out    (out_cb_out),
    .out_cr_out    (out_cr_out),
    .out_alpha_out (out_alpha_out),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Works out the pixel the core should return for one input pixel under the
  // current register copy. Luma is quantized to a multiple of the step, the
  // level count being held to the range one to 256 first, and the quantized
  // value is placed against the window whose ends are put in ascending order.
  function automatic pix_t posterize_pixel(input pix_t p);
    int   lv;
    int   stp;
    int   q;
    int   lo;
    int   hi;
    logic below;
    logic above;
    logic win_hit;
    logic desat;
    pix_t r;
    lv = int'(lvl_reg);
    if (lv < int'(LEVELS_MIN)) begin
      lv = int'(LEVELS_MIN);
    end else if (lv > int'(LEVELS_MAX)) begin
      lv = int'(LEVELS_MAX);
    end
    stp = int'(LUMA_RANGE) / lv;
    q = (int'(p.luma) / stp) * stp;
    lo = int'(thr_a_reg);
    hi = int'(thr_b_reg);
    if (hi < lo) begin
      lo = int'(thr_b_reg);
      hi = int'(thr_a_reg);
    end
    below   = (q < lo);
    above   = (q > hi);
    win_hit = !below && !above;
    r       = p;
    desat   = 1'b0;
    case (mode_reg)
      MODE_FLOOR_OUT: begin
        if (win_hit) begin
          r.luma = 8'(q);
        end else begin
          r.luma = floor_reg;
          desat  = 1'b1;
        end
      end
      MODE_POSTERIZE: begin
        r.luma = 8'(q);
        desat  = win_hit;
      end
      MODE_CLAMP: begin
        if (below) begin
          r.luma = floor_reg;
          desat  = 1'b1;
        end else if (above) begin
          r.luma = ceil_reg;
          desat  = 1'b1;
        end else begin
          r.luma = 8'(q);
        end
      end
      MODE_ALPHA_KEY: begin
        if (!win_hit) r.alpha = floor_reg;
      end
      MODE_ALPHA_Q: begin
        if (win_hit) r.alpha = 8'(q);
      end
      MODE_ALPHA_CLAMP: begin
        if (below) begin
          r.alpha = floor_reg;
        end else if (above) begin
          r.alpha = ceil_reg;
        end else begin
          r.alpha = 8'(q);
        end
      end
      default: begin
        // The two spare mode codes leave the pixel untouched.
      end
    endcase
    if (desat) begin
      r.cb = CHROMA_ZERO;
      r.cr = CHROMA_ZERO;
    end
    return r;
  endfunction

  // Matches one result beat against the oldest prediction, field by field.
  task automatic check_pixel(input pix_t got);
    pix_t want;
    if (pix_expect_q.size() == 0) begin
      bad_beats++;
      if (bad_beats <= MAX_REPORTS) begin
        $display("[%0t] result beat with nothing predicted: y=%0d cb=%0d cr=%0d a=%0d",
                 $realtime, got.luma, got.cb, got.cr, got.alpha);
      end
    end else begin
      want = pix_expect_q.pop_front();
      beats_out++;
      if (got.luma !== want.luma || got.cb !== want.cb ||
          got.cr !== want.cr || got.alpha !== want.alpha) begin
        bad_beats++;
        if (bad_beats <= MAX_REPORTS) begin
          $display("[%0t] beat %0d: want y=%0d cb=%0d cr=%0d a=%0d, got y=%0d cb=%0d cr=%0d a=%0d",
                   $realtime, beats_out - 1, want.luma, want.cb, want.cr, want.alpha,
                   got.luma, got.cb, got.cr, got.alpha);
        end
      end
    end
  endtask

  // Input driver. The prediction is taken at the edge where the beat is
  // accepted, from the payload that was on the wires. A new beat is only
  // presented once the slot is free, after the idle count drawn for the
  // previous one has run down, so valid never drops under a waiting beat.
  always @(posedge clk) begin : pixel_driver
    pix_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else begin
      if (in_valid && in_ready) begin
        pix_expect_q.push_back(posterize_pixel({in_luma_in, in_cb_in, in_cr_in, in_alpha_in}));
        beats_in++;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          in_valid <= 1'b0;
          tx_gap   <= tx_gap - 1;
        end else if (pix_pending_q.size() != 0) begin
          nxt = pix_pending_q.pop_front();
          in_valid    <= 1'b1;
          in_luma_in  <= nxt.luma;
          in_cb_in    <= nxt.cb;
          in_cr_in    <= nxt.cr;
          in_alpha_in <= nxt.alpha;
          tx_gap      <= tx_steady ? 0 : $urandom_range(0, 6);
          // Now and then switch between idling and back-to-back beats.
          if ($urandom_range(0, 31) == 0) tx_steady <= !tx_steady;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor. Each accepted beat is checked, then the receiver draws
  // how many cycles it stays away before taking the next one. While the
  // long hold-off runs, ready stays low regardless.
  always @(posedge clk) begin : pixel_monitor
    int n;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
    end else begin
      if (out_valid && out_ready) begin
        check_pixel({out_luma_out, out_cb_out, out_cr_out, out_alpha_out});
      end
      if (rx_hold) begin
        out_ready <= 1'b0;
      end else if (out_valid && out_ready) begin
        n = rx_steady ? 0 : $urandom_range(0, 6);
        rx_wait   <= n;
        out_ready <= (n == 0);
        if ($urandom_range(0, 31) == 0) rx_steady <= !rx_steady;
      end else if (rx_wait > 0) begin
        rx_wait   <= rx_wait - 1;
        out_ready <= (rx_wait == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Writes one register and keeps the bench copy in step, masked to the
  // register's width the way the core keeps it.
  task automatic write_reg(input logic [2:0] idx, input logic [8:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_LEVELS:       lvl_reg   = val;
      REG_THRESHOLD_A:  thr_a_reg = val;
      REG_THRESHOLD_B:  thr_b_reg = val;
      REG_EFFECT_MODE:  mode_reg  = val[2:0];
      REG_LUMA_FLOOR:   floor_reg = val[7:0];
      REG_LUMA_CEILING: ceil_reg  = val[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_window(input logic [8:0] lv, input logic [8:0] ta, input logic [8:0] tb,
                            input logic [8:0] md, input logic [8:0] fl, input logic [8:0] cl);
    write_reg(REG_LEVELS, lv);
    write_reg(REG_THRESHOLD_A, ta);
    write_reg(REG_THRESHOLD_B, tb);
    write_reg(REG_EFFECT_MODE, md);
    write_reg(REG_LUMA_FLOOR, fl);
    write_reg(REG_LUMA_CEILING, cl);
    settings++;
    modes_seen[md[2:0]] = 1'b1;
  endtask

  // Registers may only change with the pipeline empty: nothing left to send,
  // nothing on the input, every prediction matched, and then a settle wait.
  task automatic wait_idle();
    do @(negedge clk);
    while (pix_pending_q.size() != 0 || in_valid || pix_expect_q.size() != 0);
    repeat (PIPE_SETTLE) @(negedge clk);
  endtask

  // Holds the receiver off long enough for the pipeline to fill and push
  // back on the input while the driver keeps offering beats.
  task automatic hold_receiver();
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  endtask

  function automatic logic [8:0] pick_threshold();
    case ($urandom_range(0, 7))
      0:       return 9'd0;
      1:       return 9'd256;
      2:       return 9'($urandom_range(257, 511));
      default: return 9'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [8:0] pick_luma_level();
    logic [7:0] v;
    case ($urandom_range(0, 5))
      0:       v = 8'd0;
      1:       v = 8'd255;
      default: v = 8'($urandom_range(0, 255));
    endcase
    // A random top data bit is added; the 8-bit registers must drop it.
    return {1'($urandom_range(0, 1)), v};
  endfunction

  initial begin : stimulus
    int   m;
    int   k;
    int   phase;
    int   ph_len;
    int   queued;
    logic [8:0] lv;
    logic [2:0] md;
    pix_t px;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: one short set of beats per mode code. The first set
    // runs on the reset values; the others cover a zero level count, counts
    // beyond 256, reversed window ends, ends above 256, a single-point and an
    // empty-looking window, and both spare mode codes.
    for (m = 0; m < 8; m++) begin
      wait_idle();
      case (m)
        0: modes_seen[RST_EFFECT_MODE] = 1'b1;
        1: set_window(9'd0,   9'd0,   9'd255, {6'd0, MODE_POSTERIZE},   9'd0,   9'd255);
        2: set_window(9'd511, 9'd64,  9'd192, {6'd0, MODE_CLAMP},       9'd255, 9'd0);
        3: set_window(9'd256, 9'd200, 9'd40,  {6'd0, MODE_ALPHA_KEY},   9'd7,   9'd250);
        4: set_window(9'd2,   9'd0,   9'd300, {6'd0, MODE_ALPHA_Q},     9'd16,  9'd235);
        5: set_window(9'd3,   9'd257, 9'd511, {6'd0, MODE_ALPHA_CLAMP}, 9'd1,   9'd254);
        6: set_window(9'd1,   9'd100, 9'd100, {6'd0, MODE_RSVD6},       9'd32,  9'd200);
        default: set_window(9'd255, 9'd0, 9'd0, {6'd0, MODE_RSVD7},     9'd48,  9'd180);
      endcase
      pix_pending_q.push_back('{luma: 8'h00, cb: 8'hFF, cr: 8'h00, alpha: 8'hFF});
      pix_pending_q.push_back('{luma: 8'hFF, cb: 8'h00, cr: 8'hFF, alpha: 8'h00});
      pix_pending_q.push_back('{luma: 8'h80, cb: 8'h55, cr: 8'hAA, alpha: 8'h7F});
    end

    // Random part: short phases, each under a fresh setting with a bias
    // toward the ends of every register's range. Small level counts are
    // favored since they give the coarsest and most telling quantization.
    queued = 0;
    phase  = 0;
    while (queued < RANDOM_BEATS) begin
      wait_idle();
      case ($urandom_range(0, 5))
        0:       lv = 9'd0;
        1:       lv = 9'd256;
        2:       lv = 9'($urandom_range(257, 511));
        3:       lv = 9'($urandom_range(0, 511));
        default: lv = 9'($urandom_range(1, 16));
      endcase
      md = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      set_window(lv, pick_threshold(), pick_threshold(), {6'($urandom_range(0, 63)), md},
                 pick_luma_level(), pick_luma_level());
      ph_len = (phase == 2) ? 64 : $urandom_range(20, 80);
      if (phase == 2) begin
        fork
          hold_receiver();
        join_none
      end
      for (k = 0; k < ph_len; k++) begin
        px.luma  = 8'($urandom_range(0, 255));
        px.cb    = 8'($urandom_range(0, 255));
        px.cr    = 8'($urandom_range(0, 255));
        px.alpha = 8'($urandom_range(0, 255));
        pix_pending_q.push_back(px);
      end
      queued += ph_len;
      phase++;
    end

    // Drain: everything sent must come back, then a quiet spell in which a
    // stray beat would still be caught by the monitor.
    wait_idle();
    repeat (PIPE_SETTLE) @(posedge clk);
    if (pix_expect_q.size() != 0) bad_beats += pix_expect_q.size();

    $display("Ran %0d pixel beats in, %0d out, across %0d register settings (mode codes %b).",
             beats_in, beats_out, settings, modes_seen);
    $display("Output held off once for %0d cycles; %0d beats failed the check.",
             HOLD_CYCLES, bad_beats);
    if (bad_beats == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin : watchdog
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
